// ----- hw/rtl/bitap_pkg.sv -----
// shared types and codes of the approximate prefix matcher
package bitap_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_PROBE = 2'd2
  } mode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_LIMIT    = 1'b1;

  // field widths fixed by the interface
  localparam int unsigned CfgDataW  = 6;
  localparam int unsigned DepthW    = 6;
  localparam int unsigned SymbolW   = 8;
  localparam int unsigned MaskBitsW = 32;
  localparam int unsigned MaskDepth = 256;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/bitap_ctrl.sv -----
// controller state machine of the approximate prefix matcher
module bitap_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output bitap_pkg::dp_cmd_t cmd_o
);

  bitap_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bitap_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = bitap_pkg::ST_EXEC;
        end
      end
      bitap_pkg::ST_EXEC: begin
        state_d = bitap_pkg::ST_IDLE;
      end
      default: begin
        state_d = bitap_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o        = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      bitap_pkg::ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      bitap_pkg::ST_EXEC: begin
        busy_o        = 1'b1;
        cmd_o.execute = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bitap_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a word is executed in the cycle after it is captured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute && !cmd_o.capture)
    else $error("capture not followed by execute");

  // busy lasts a single cycle per word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> $past(start_i && !busy_o))
    else $error("busy without a preceding accept");

endmodule

// ----- hw/rtl/bitap_dp.sv -----
// datapath of the approximate prefix matcher: tables, row store, recurrence
module bitap_dp #(
  parameter int unsigned PatternBits = 32,
  parameter int unsigned MaxErrors   = 3,
  parameter int unsigned MaxDepth    = 36
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bitap_pkg::dp_cmd_t                   cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [bitap_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bitap_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [1:0]                           mode_i,
  input  logic [bitap_pkg::DepthW-1:0]         depth_i,
  input  logic [bitap_pkg::SymbolW-1:0]        symbol_i,
  input  logic [bitap_pkg::MaskBitsW-1:0]      mask_bits_i,
  output logic                                 done_o,
  output logic                                 viable_o,
  output logic                                 match_o
);

  localparam int unsigned Slots = MaxDepth - 1;
  localparam int unsigned AW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned Lanes = MaxErrors + 1;
  localparam int unsigned KW    = (MaxErrors > 0) ? $clog2(MaxErrors + 1) : 1;
  localparam int unsigned MW    = $clog2(PatternBits + 1);
  localparam int unsigned BW    = $clog2(PatternBits);

  // configuration
  logic [5:0] cfg_m_q;
  logic [1:0] cfg_k_q;
  logic [MW-1:0] m_eff;
  logic [KW-1:0] k_eff;
  logic [BW-1:0] mbit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_m_q <= 6'd1;
      cfg_k_q <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bitap_pkg::CFG_PATTERN_LENGTH: cfg_m_q <= cfg_data_i;
        bitap_pkg::CFG_ERROR_LIMIT:    cfg_k_q <= cfg_data_i[1:0];
        default:                       cfg_m_q <= cfg_m_q;
      endcase
    end
  end

  always_comb begin
    if (cfg_m_q == '0) begin
      m_eff = MW'(1);
    end else if (int'(cfg_m_q) > int'(PatternBits)) begin
      m_eff = MW'(PatternBits);
    end else begin
      m_eff = MW'(cfg_m_q);
    end
    if (int'(cfg_k_q) > int'(MaxErrors)) begin
      k_eff = KW'(MaxErrors);
    end else begin
      k_eff = KW'(cfg_k_q);
    end
    mbit = BW'(m_eff - MW'(1));
  end

  // captured word
  logic [1:0]                        mode_q;
  logic [bitap_pkg::DepthW-1:0]      depth_q;
  logic [bitap_pkg::SymbolW-1:0]     sym_q;
  logic [bitap_pkg::MaskBitsW-1:0]   mbits_q;
  logic [PatternBits-1:0]            mask_rd_q;
  logic                              mask_hit_q;
  logic [PatternBits-1:0]            rows_rd_q [Lanes];

  // mask table with per-entry valid bits standing in for the cleared reset
  logic [PatternBits-1:0]            mask_mem [bitap_pkg::MaskDepth];
  logic [bitap_pkg::MaskDepth-1:0]   mask_vld_q;
  logic                              mask_we;

  // row store read port, addressed by the previous depth
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  always_comb begin
    rd_ok   = (depth_i != '0) && ((int'(depth_i) - 1) < int'(Slots));
    rd_addr = AW'(int'(depth_i) - 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_i;
      depth_q    <= depth_i;
      sym_q      <= symbol_i;
      mbits_q    <= mask_bits_i;
      mask_rd_q  <= mask_mem[symbol_i];
      mask_hit_q <= mask_vld_q[symbol_i];
    end
    if (mask_we) begin
      mask_mem[sym_q] <= PatternBits'(mbits_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_vld_q <= '0;
    end else if (mask_we) begin
      mask_vld_q[sym_q] <= 1'b1;
    end
  end

  // recurrence
  logic [PatternBits-1:0] init_rows [Lanes];
  logic [PatternBits-1:0] rows_src  [Lanes];
  logic [PatternBits-1:0] new_rows  [Lanes];
  logic [PatternBits-1:0] sym_mask;
  logic [PatternBits-1:0] new_k;
  logic                   slot_ok;
  logic                   step_ok;
  logic                   row_we;
  logic [Lanes-1:0]       lane_we;
  logic [AW-1:0]          wr_addr;
  logic                   viable_d;
  logic                   match_d;

  function automatic logic [PatternBits-1:0] shl1(input logic [PatternBits-1:0] x);
    shl1 = {x[PatternBits-2:0], 1'b1};
  endfunction

  always_comb begin
    sym_mask = mask_hit_q ? mask_rd_q : '0;
    for (int l = 0; l < int'(Lanes); l++) begin
      init_rows[l] = {PatternBits{1'b1}} >> (PatternBits - 1 - l);
      rows_src[l]  = (depth_q == '0) ? init_rows[l] : rows_rd_q[l];
    end
    new_rows[0] = shl1(rows_src[0]) & sym_mask;
    for (int l = 1; l < int'(Lanes); l++) begin
      new_rows[l] = (shl1(rows_src[l]) & sym_mask) | shl1(rows_src[l-1])
                  | shl1(new_rows[l-1]) | rows_src[l-1];
    end
    new_k = new_rows[k_eff];

    slot_ok = (depth_q == '0) || ((int'(depth_q) - 1) < int'(Slots));
    step_ok = (int'(depth_q) < (int'(m_eff) + int'(k_eff)))
           && (int'(depth_q) < int'(Slots));
    wr_addr = AW'(depth_q);

    mask_we  = 1'b0;
    row_we   = 1'b0;
    viable_d = 1'b0;
    match_d  = 1'b0;
    if (cmd_i.execute) begin
      case (bitap_pkg::mode_e'(mode_q))
        bitap_pkg::MODE_LOAD: begin
          mask_we = 1'b1;
        end
        bitap_pkg::MODE_STEP: begin
          row_we   = step_ok;
          viable_d = step_ok && (int'(depth_q) < int'(PatternBits))
                  && new_k[BW'(depth_q)];
        end
        bitap_pkg::MODE_PROBE: begin
          match_d = slot_ok && rows_src[k_eff][mbit];
        end
        default: begin
          mask_we = 1'b0;
        end
      endcase
    end

    // only rows 0..k of a depth are written
    for (int l = 0; l < int'(Lanes); l++) begin
      lane_we[l] = row_we && (l <= int'(k_eff));
    end
  end

  // row store, one memory per error row
  for (genvar l = 0; l < int'(Lanes); l++) begin : g_lane
    logic [PatternBits-1:0] row_mem [Slots];

    always_ff @(posedge clk_i) begin
      if (lane_we[l]) begin
        row_mem[wr_addr] <= new_rows[l];
      end
      if (cmd_i.capture && rd_ok) begin
        rows_rd_q[l] <= row_mem[rd_addr];
      end
    end
  end

  // result register
  logic done_q, viable_q, match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      viable_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      done_q   <= cmd_i.execute;
      viable_q <= viable_d;
      match_q  <= match_d;
    end
  end

  assign done_o   = done_q;
  assign viable_o = viable_q;
  assign match_o  = match_q;

  // one result per executed word, the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q == $past(cmd_i.execute))
    else $error("result strobe out of step with execute");

  // a word answers viable or match, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(viable_q && match_q))
    else $error("viable and match both set");

  // table writes never overlap a capture read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_we || row_we) |-> !cmd_i.capture)
    else $error("store write in a capture cycle");

endmodule

// ----- hw/rtl/bitap_k_error_trie_step.sv -----
// top level of the approximate prefix matcher for trie walks
// A word is taken at a rising edge where start is high and busy is low; busy then
// stays high for one cycle while the datapath runs the word, and done_o pulses for
// exactly one cycle in the cycle after that with viable_o and match_o valid. The
// receiver cannot stall: the result must be taken in that cycle. A new word may be
// started in the same cycle that the previous result is shown, but the block takes
// no new word while one executes. This is set by the row store, which is read at
// the accept edge and written at the end of the execute cycle, so that a step at
// the next depth reads the rows its predecessor just wrote. Mode 0 loads one entry
// of the 256-entry mask table; entries never loaded read as zero through per-entry
// valid bits, so there is no clearing pass after reset. Mode 1 steps the k+1 error
// rows by one symbol and reports viable; mode 2 probes a word end and reports
// match; every other word answers with both flags low. Rows of a depth that no
// step has written read as anything. Configuration writes are taken at any edge
// with cfg_we_i high, and must only be issued while no word is in flight.
module bitap_k_error_trie_step #(
  parameter int unsigned PatternBits = 32,
  parameter int unsigned MaxErrors   = 3,
  parameter int unsigned MaxDepth    = 36
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command handshake
  input  logic                              start,
  output logic                              busy,
  // word payload
  input  logic [1:0]                        mode_i,
  input  logic [bitap_pkg::DepthW-1:0]      depth_i,
  input  logic [bitap_pkg::SymbolW-1:0]     symbol_i,
  input  logic [bitap_pkg::MaskBitsW-1:0]   mask_bits_i,
  // result
  output logic                              done_o,
  output logic                              viable_o,
  output logic                              match_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bitap_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bitap_pkg::CfgDataW-1:0]    cfg_data_i
);

  // command group from the state machine to the datapath
  bitap_pkg::dp_cmd_t cmd;

  // two-state controller: idle waits for start, exec runs the captured word
  bitap_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // tables, row store, recurrence and result register
  bitap_dp #(
    .PatternBits (PatternBits),
    .MaxErrors   (MaxErrors),
    .MaxDepth    (MaxDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .depth_i     (depth_i),
    .symbol_i    (symbol_i),
    .mask_bits_i (mask_bits_i),
    .done_o      (done_o),
    .viable_o    (viable_o),
    .match_o     (match_o)
  );

endmodule
